>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, codes and the micro-program of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    // operation codes on the input channel
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // working register file indexes
    localparam logic [2:0] R_N1 = 3'd0;
    localparam logic [2:0] R_D1 = 3'd1;
    localparam logic [2:0] R_N2 = 3'd2;
    localparam logic [2:0] R_D2 = 3'd3;
    localparam logic [2:0] R_T1 = 3'd4;
    localparam logic [2:0] R_T2 = 3'd5;
    localparam logic [2:0] R_L  = 3'd6;
    localparam logic [2:0] R_G  = 3'd7;

    // program entry points
    localparam logic [5:0] PC_ADD = 6'd23;
    localparam logic [5:0] PC_MUL = 6'd39;
    localparam logic [5:0] PC_DIV = 6'd42;
    localparam logic [5:0] PC_RED = 6'd44;
    localparam logic [5:0] PC_CMP = 6'd55;

    typedef enum logic [4:0] {
        UOP_LD,
        UOP_FIT,
        UOP_NORMN,
        UOP_NORMD,
        UOP_GCD,
        UOP_DIV,
        UOP_MUL,
        UOP_NEG,
        UOP_ADD,
        UOP_MOV,
        UOP_LT,
        UOP_EQ0,
        UOP_EQ1,
        UOP_FINAL,
        UOP_BROP,
        UOP_BRCMP,
        UOP_SKIPNSUB,
        UOP_JMP,
        UOP_END
    } uop_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_CHECK,
        CS_FETCH,
        CS_EXEC,
        CS_WAIT,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        uop_t       uop;
        logic [2:0] ra;
        logic [2:0] rb;
        logic [2:0] rd;
        logic [5:0] target;
    } ucode_t;

    typedef struct packed {
        logic       load_in;
        logic       clear;
        logic       fetch;
        logic       go;
        uop_t       uop;
        logic [2:0] ra;
        logic [2:0] rb;
        logic [2:0] rd;
        logic       out_load;
        logic       out_zero;
        logic       out_flags;
    } dp_cmd_t;

    typedef struct packed {
        logic ovf;
        logic done;
        logic zero_den;
        logic b_zero;
    } dp_stat_t;

    // micro-program: operand reduction, then per-operation sequences
    function automatic ucode_t ucode_rom(input logic [5:0] pc);
        ucode_t ins;
        unique case (pc)
            // load and check operands
            6'd0:  ins = '{UOP_LD,    R_N1, R_N1, R_N1, 6'd0};
            6'd1:  ins = '{UOP_LD,    R_D1, R_N1, R_D1, 6'd0};
            6'd2:  ins = '{UOP_LD,    R_N2, R_N1, R_N2, 6'd0};
            6'd3:  ins = '{UOP_LD,    R_D2, R_N1, R_D2, 6'd0};
            6'd4:  ins = '{UOP_FIT,   R_N1, R_N1, R_N1, 6'd0};
            6'd5:  ins = '{UOP_FIT,   R_D1, R_N1, R_N1, 6'd0};
            6'd6:  ins = '{UOP_FIT,   R_N2, R_N1, R_N1, 6'd0};
            6'd7:  ins = '{UOP_FIT,   R_D2, R_N1, R_N1, 6'd0};
            // reduce left operand
            6'd8:  ins = '{UOP_NORMN, R_N1, R_D1, R_N1, 6'd0};
            6'd9:  ins = '{UOP_NORMD, R_N1, R_D1, R_D1, 6'd0};
            6'd10: ins = '{UOP_FIT,   R_N1, R_N1, R_N1, 6'd0};
            6'd11: ins = '{UOP_FIT,   R_D1, R_N1, R_N1, 6'd0};
            6'd12: ins = '{UOP_GCD,   R_N1, R_D1, R_G,  6'd0};
            6'd13: ins = '{UOP_DIV,   R_N1, R_G,  R_N1, 6'd0};
            6'd14: ins = '{UOP_DIV,   R_D1, R_G,  R_D1, 6'd0};
            // reduce right operand
            6'd15: ins = '{UOP_NORMN, R_N2, R_D2, R_N2, 6'd0};
            6'd16: ins = '{UOP_NORMD, R_N2, R_D2, R_D2, 6'd0};
            6'd17: ins = '{UOP_FIT,   R_N2, R_N1, R_N1, 6'd0};
            6'd18: ins = '{UOP_FIT,   R_D2, R_N1, R_N1, 6'd0};
            6'd19: ins = '{UOP_GCD,   R_N2, R_D2, R_G,  6'd0};
            6'd20: ins = '{UOP_DIV,   R_N2, R_G,  R_N2, 6'd0};
            6'd21: ins = '{UOP_DIV,   R_D2, R_G,  R_D2, 6'd0};
            6'd22: ins = '{UOP_BROP,  R_N1, R_N1, R_N1, 6'd0};
            // scale to common denominator, then branch to compare or add/subtract
            6'd23: ins = '{UOP_GCD,   R_D1, R_D2, R_G,  6'd0};
            6'd24: ins = '{UOP_DIV,   R_D1, R_G,  R_L,  6'd0};
            6'd25: ins = '{UOP_MUL,   R_L,  R_D2, R_L,  6'd0};
            6'd26: ins = '{UOP_FIT,   R_L,  R_N1, R_N1, 6'd0};
            6'd27: ins = '{UOP_DIV,   R_L,  R_D1, R_T1, 6'd0};
            6'd28: ins = '{UOP_MUL,   R_N1, R_T1, R_T1, 6'd0};
            6'd29: ins = '{UOP_DIV,   R_L,  R_D2, R_T2, 6'd0};
            6'd30: ins = '{UOP_MUL,   R_N2, R_T2, R_T2, 6'd0};
            6'd31: ins = '{UOP_FIT,   R_T1, R_N1, R_N1, 6'd0};
            6'd32: ins = '{UOP_FIT,   R_T2, R_N1, R_N1, 6'd0};
            6'd33: ins = '{UOP_BRCMP, R_N1, R_N1, R_N1, PC_CMP};
            6'd34: ins = '{UOP_SKIPNSUB, R_N1, R_N1, R_N1, 6'd0};
            6'd35: ins = '{UOP_NEG,   R_T2, R_N1, R_T2, 6'd0};
            6'd36: ins = '{UOP_ADD,   R_T1, R_T2, R_T1, 6'd0};
            6'd37: ins = '{UOP_MOV,   R_L,  R_N1, R_T2, 6'd0};
            6'd38: ins = '{UOP_JMP,   R_N1, R_N1, R_N1, PC_RED};
            // multiply
            6'd39: ins = '{UOP_MUL,   R_N1, R_N2, R_T1, 6'd0};
            6'd40: ins = '{UOP_MUL,   R_D1, R_D2, R_T2, 6'd0};
            6'd41: ins = '{UOP_JMP,   R_N1, R_N1, R_N1, PC_RED};
            // divide
            6'd42: ins = '{UOP_MUL,   R_N1, R_D2, R_T1, 6'd0};
            6'd43: ins = '{UOP_MUL,   R_D1, R_N2, R_T2, 6'd0};
            // reduce result
            6'd44: ins = '{UOP_FIT,   R_T1, R_N1, R_N1, 6'd0};
            6'd45: ins = '{UOP_FIT,   R_T2, R_N1, R_N1, 6'd0};
            6'd46: ins = '{UOP_NORMN, R_T1, R_T2, R_T1, 6'd0};
            6'd47: ins = '{UOP_NORMD, R_T1, R_T2, R_T2, 6'd0};
            6'd48: ins = '{UOP_FIT,   R_T1, R_N1, R_N1, 6'd0};
            6'd49: ins = '{UOP_FIT,   R_T2, R_N1, R_N1, 6'd0};
            6'd50: ins = '{UOP_GCD,   R_T1, R_T2, R_G,  6'd0};
            6'd51: ins = '{UOP_DIV,   R_T1, R_G,  R_T1, 6'd0};
            6'd52: ins = '{UOP_DIV,   R_T2, R_G,  R_T2, 6'd0};
            6'd53: ins = '{UOP_FINAL, R_T1, R_T2, R_N1, 6'd0};
            6'd54: ins = '{UOP_END,   R_N1, R_N1, R_N1, 6'd0};
            // compare
            6'd55: ins = '{UOP_LT,    R_T1, R_T2, R_N1, 6'd0};
            6'd56: ins = '{UOP_EQ0,   R_N1, R_N2, R_N1, 6'd0};
            6'd57: ins = '{UOP_EQ1,   R_D1, R_D2, R_N1, 6'd0};
            default: ins = '{UOP_END, R_N1, R_N1, R_N1, 6'd0};
        endcase
        return ins;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, register file, shared iterative unit
// (divide, multiply, binary gcd) and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_dp
    import rau_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic signed [31:0] a_num,
    input  wire logic signed [31:0] a_den,
    input  wire logic signed [31:0] b_num,
    input  wire logic signed [31:0] b_den,
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat,
    output logic signed [31:0]      result_num,
    output logic [30:0]             result_den,
    output logic                    less,
    output logic                    equal
);

    localparam int MW = VALUE_BITS;
    localparam int PW = (2 * MW > 33) ? 2 * MW : 33;
    localparam int CW = $clog2(MW + 1);
    localparam int KW = $clog2(MW);

    // value fits a signed MW-bit word
    function automatic logic fits_v(input logic neg, input logic [PW-1:0] mag);
        logic up_zero;
        logic edge_hit;
        up_zero  = (mag >> (MW - 1)) == '0;
        edge_hit = mag == (PW'(1) << (MW - 1));
        return neg ? (up_zero || edge_hit) : up_zero;
    endfunction

    // value fits the 32-bit result field
    function automatic logic fits32(input logic neg, input logic [PW-1:0] mag);
        logic up_zero;
        logic edge_hit;
        up_zero  = (mag >> 31) == '0;
        edge_hit = mag == (PW'(1) << 31);
        return neg ? (up_zero || edge_hit) : up_zero;
    endfunction

    logic [31:0]   in_reg [4];
    logic [PW-1:0] rf_mag [8];
    logic          rf_neg [8];
    logic [PW-1:0] opa_mag_reg, opb_mag_reg;
    logic          opa_neg_reg, opb_neg_reg;
    logic          ovf_reg, ovf_next;
    logic          lt_reg, lt_next;
    logic          eq_reg, eq_next;

    logic          wr_en;
    logic [2:0]    wr_idx;
    logic [PW-1:0] wr_mag;
    logic          wr_neg;
    logic [31:0]   ld_raw;
    logic [31:0]   ld_mag;

    // iterative unit
    logic          busy_reg;
    uop_t          unit_op_reg;
    logic [2:0]    rd_reg;
    logic          res_neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [MW-1:0] quo_reg, dvs_reg;
    logic [MW:0]   rem_reg;
    logic [PW-1:0] prod_reg, mcand_reg;
    logic [MW-1:0] mplier_reg;
    logic [MW-1:0] gx_reg, gy_reg;
    logic [KW-1:0] gk_reg;

    logic          unit_start;
    logic          unit_fin;
    logic [PW-1:0] unit_mag;
    logic [MW:0]   r_sh;
    logic          q_bit;
    logic [MW:0]   r_new;
    logic [MW-1:0] q_new;
    logic [PW-1:0] p_new;
    logic          last_step;
    logic [MW-1:0] g_res;

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg[0] <= a_num;
            in_reg[1] <= a_den;
            in_reg[2] <= b_num;
            in_reg[3] <= b_den;
        end
    end

    assign stat.zero_den = (in_reg[1] == '0) || (in_reg[3] == '0);
    assign stat.b_zero   = (in_reg[2] == '0);
    assign stat.ovf      = ovf_reg;
    assign stat.done     = unit_fin;

    // operand fetch from register file
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            opa_mag_reg <= rf_mag[cmd.ra];
            opa_neg_reg <= rf_neg[cmd.ra];
            opb_mag_reg <= rf_mag[cmd.rb];
            opb_neg_reg <= rf_neg[cmd.rb];
        end
    end

    // iterative unit step logic
    always_comb
    begin
        r_sh      = {rem_reg[MW-1:0], quo_reg[MW-1]};
        q_bit     = r_sh >= {1'b0, dvs_reg};
        r_new     = q_bit ? (r_sh - {1'b0, dvs_reg}) : r_sh;
        q_new     = {quo_reg[MW-2:0], q_bit};
        p_new     = mplier_reg[0] ? (prod_reg + mcand_reg) : prod_reg;
        last_step = cnt_reg == CW'(MW - 1);
        g_res     = ((gx_reg == '0) ? gy_reg : gx_reg) << gk_reg;
        unit_fin  = 1'b0;
        unit_mag  = '0;
        if (busy_reg)
        begin
            unique case (unit_op_reg)
                UOP_DIV:
                begin
                    unit_fin = last_step;
                    unit_mag = PW'(q_new);
                end
                UOP_MUL:
                begin
                    unit_fin = last_step;
                    unit_mag = p_new;
                end
                default:
                begin
                    unit_fin = (gx_reg == '0) || (gy_reg == '0);
                    unit_mag = PW'(g_res);
                end
            endcase
        end
    end

    assign unit_start = cmd.go &&
        (cmd.uop == UOP_DIV || cmd.uop == UOP_MUL || cmd.uop == UOP_GCD);

    // iterative unit control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (unit_start)
        begin
            busy_reg <= 1'b1;
        end
        else if (unit_fin)
        begin
            busy_reg <= 1'b0;
        end
    end

    // iterative unit operands
    always_ff @(posedge clk)
    begin
        if (unit_start)
        begin
            unit_op_reg <= cmd.uop;
            rd_reg      <= cmd.rd;
            cnt_reg     <= '0;
            quo_reg     <= opa_mag_reg[MW-1:0];
            dvs_reg     <= opb_mag_reg[MW-1:0];
            rem_reg     <= '0;
            prod_reg    <= '0;
            mcand_reg   <= PW'(opa_mag_reg[MW-1:0]);
            mplier_reg  <= opb_mag_reg[MW-1:0];
            gx_reg      <= opa_mag_reg[MW-1:0];
            gy_reg      <= opb_mag_reg[MW-1:0];
            gk_reg      <= '0;
            unique case (cmd.uop)
                UOP_DIV: res_neg_reg <= opa_neg_reg;
                UOP_MUL: res_neg_reg <= opa_neg_reg ^ opb_neg_reg;
                default: res_neg_reg <= 1'b0;
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg    <= cnt_reg + CW'(1);
            quo_reg    <= q_new;
            rem_reg    <= r_new;
            prod_reg   <= p_new;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            // binary gcd step
            priority if (gx_reg == '0 || gy_reg == '0)
            begin
                gx_reg <= gx_reg;
            end
            else if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + KW'(1);
            end
            else if (!gx_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
            end
            else if (!gy_reg[0])
            begin
                gy_reg <= gy_reg >> 1;
            end
            else if (gx_reg >= gy_reg)
            begin
                gx_reg <= gx_reg - gy_reg;
            end
            else
            begin
                gy_reg <= gy_reg - gx_reg;
            end
        end
    end

    // combinational operations and write-back
    always_comb
    begin
        wr_en    = 1'b0;
        wr_idx   = cmd.rd;
        wr_mag   = '0;
        wr_neg   = 1'b0;
        ovf_next = ovf_reg;
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        ld_raw   = in_reg[cmd.ra[1:0]];
        ld_mag   = ld_raw[31] ? (~ld_raw + 32'd1) : ld_raw;
        if (cmd.clear)
        begin
            ovf_next = 1'b0;
            lt_next  = 1'b0;
            eq_next  = 1'b0;
        end
        if (unit_fin)
        begin
            wr_en  = 1'b1;
            wr_idx = rd_reg;
            wr_mag = unit_mag;
            wr_neg = res_neg_reg;
        end
        else if (cmd.go)
        begin
            unique case (cmd.uop)
                UOP_LD:
                begin
                    wr_en  = 1'b1;
                    wr_mag = PW'(ld_mag);
                    wr_neg = ld_raw[31];
                end
                UOP_FIT:
                begin
                    ovf_next = ovf_reg || !fits_v(opa_neg_reg, opa_mag_reg);
                end
                UOP_NORMN:
                begin
                    wr_en  = 1'b1;
                    wr_mag = opa_mag_reg;
                    wr_neg = opa_neg_reg ^ opb_neg_reg;
                end
                UOP_NORMD:
                begin
                    wr_en  = 1'b1;
                    wr_mag = (opa_mag_reg == '0) ? PW'(1) : opb_mag_reg;
                end
                UOP_NEG:
                begin
                    wr_en  = 1'b1;
                    wr_mag = opa_mag_reg;
                    wr_neg = !opa_neg_reg;
                end
                UOP_ADD:
                begin
                    wr_en = 1'b1;
                    priority if (opa_neg_reg == opb_neg_reg)
                    begin
                        wr_mag = opa_mag_reg + opb_mag_reg;
                        wr_neg = opa_neg_reg;
                    end
                    else if (opa_mag_reg >= opb_mag_reg)
                    begin
                        wr_mag = opa_mag_reg - opb_mag_reg;
                        wr_neg = opa_neg_reg;
                    end
                    else
                    begin
                        wr_mag = opb_mag_reg - opa_mag_reg;
                        wr_neg = opb_neg_reg;
                    end
                end
                UOP_MOV:
                begin
                    wr_en  = 1'b1;
                    wr_mag = opa_mag_reg;
                    wr_neg = opa_neg_reg;
                end
                UOP_LT:
                begin
                    priority if (opa_neg_reg != opb_neg_reg)
                        lt_next = opa_neg_reg;
                    else if (opa_neg_reg)
                        lt_next = opa_mag_reg > opb_mag_reg;
                    else
                        lt_next = opa_mag_reg < opb_mag_reg;
                end
                UOP_EQ0:
                begin
                    eq_next = (opa_neg_reg == opb_neg_reg) && (opa_mag_reg == opb_mag_reg);
                end
                UOP_EQ1:
                begin
                    eq_next = eq_reg && (opa_mag_reg == opb_mag_reg);
                end
                UOP_FINAL:
                begin
                    ovf_next = ovf_reg || !fits32(opa_neg_reg, opa_mag_reg) ||
                               (opb_mag_reg > PW'(32'h7FFF_FFFF));
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        // zero carries no sign
        wr_neg = wr_neg && (wr_mag != '0);
    end

    // register file write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mag[wr_idx] <= wr_mag;
            rf_neg[wr_idx] <= wr_neg;
        end
    end

    // sticky flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg <= 1'b0;
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
        end
        else
        begin
            ovf_reg <= ovf_next;
            lt_reg  <= lt_next;
            eq_reg  <= eq_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_zero)
            begin
                result_num <= '0;
                result_den <= 31'd1;
            end
            else
            begin
                result_num <= opa_neg_reg ? -opa_mag_reg[31:0] : opa_mag_reg[31:0];
                result_den <= opb_mag_reg[30:0];
            end
            less  <= cmd.out_flags && lt_reg;
            equal <= cmd.out_flags && eq_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Controller: handshakes, input checks and the micro-program sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] operation,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      status,
    output dp_cmd_t         cmd,
    input  wire dp_stat_t   stat
);

    ctrl_state_t state_reg, state_next;
    logic [5:0]  pc_reg, pc_next;
    logic [2:0]  op_reg, op_next;
    logic [1:0]  st_reg, st_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    ucode_t      ins;

    assign ins       = ucode_rom(pc_reg);
    assign in_stall  = (state_reg != CS_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            pc_reg        <= '0;
            op_reg        <= OP_ADD;
            st_reg        <= ST_OK;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            op_reg        <= op_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        op_next       = op_reg;
        st_next       = st_reg;
        status_next   = status_reg;
        cmd.load_in   = 1'b0;
        cmd.clear     = 1'b0;
        cmd.fetch     = 1'b0;
        cmd.go        = 1'b0;
        cmd.uop       = ins.uop;
        cmd.ra        = ins.ra;
        cmd.rb        = ins.rb;
        cmd.rd        = ins.rd;
        cmd.out_load  = 1'b0;
        cmd.out_zero  = (st_reg != ST_OK) || (op_reg >= OP_CMP);
        cmd.out_flags = (st_reg == ST_OK) && (op_reg == OP_CMP);

        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.clear   = 1'b1;
                    op_next     = operation;
                    state_next  = CS_CHECK;
                end
            end
            CS_CHECK:
            begin
                pc_next = '0;
                priority if (op_reg > OP_CMP)
                begin
                    st_next    = ST_OK;
                    state_next = CS_DONE;
                end
                else if (stat.zero_den)
                begin
                    st_next    = ST_ZERO_DEN;
                    state_next = CS_DONE;
                end
                else if (op_reg == OP_DIV && stat.b_zero)
                begin
                    st_next    = ST_DIV_ZERO;
                    state_next = CS_DONE;
                end
                else
                begin
                    st_next    = ST_OK;
                    state_next = CS_FETCH;
                end
            end
            CS_FETCH:
            begin
                if (stat.ovf)
                begin
                    st_next    = ST_OVERFLOW;
                    state_next = CS_DONE;
                end
                else
                begin
                    unique case (ins.uop)
                        UOP_BROP:
                        begin
                            priority if (op_reg == OP_MUL)
                                pc_next = PC_MUL;
                            else if (op_reg == OP_DIV)
                                pc_next = PC_DIV;
                            else
                                pc_next = PC_ADD;
                        end
                        UOP_BRCMP:
                            pc_next = (op_reg == OP_CMP) ? ins.target : pc_reg + 6'd1;
                        UOP_SKIPNSUB:
                            pc_next = (op_reg == OP_SUB) ? pc_reg + 6'd1 : pc_reg + 6'd2;
                        UOP_JMP:
                            pc_next = ins.target;
                        UOP_END:
                            state_next = CS_DONE;
                        default:
                        begin
                            cmd.fetch  = 1'b1;
                            state_next = CS_EXEC;
                        end
                    endcase
                end
            end
            CS_EXEC:
            begin
                cmd.go = 1'b1;
                if (ins.uop == UOP_GCD || ins.uop == UOP_DIV || ins.uop == UOP_MUL)
                begin
                    state_next = CS_WAIT;
                end
                else
                begin
                    pc_next    = pc_reg + 6'd1;
                    state_next = CS_FETCH;
                end
            end
            CS_WAIT:
            begin
                if (stat.done)
                begin
                    pc_next    = pc_reg + 6'd1;
                    state_next = CS_FETCH;
                end
            end
            CS_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    status_next  = st_reg;
                    state_next   = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // output beat holding
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

endmodule

`default_nettype wire

>>> rtl/rational_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Reduced-fraction add, subtract, multiply, divide and compare.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one beat: operation and two
//   fractions a_num/a_den and b_num/b_den. Output channel (out_valid /
//   out_stall) returns one beat per input: reduced result_num/result_den,
//   less/equal for compare, and status.
//   One item is worked on at a time; in_stall stays high from acceptance
//   until the result is placed in the output register. The next input beat
//   can be taken while that result still waits on a stalled receiver.
//   Run time is set by the shared iterative unit (divide, multiply and
//   binary gcd) and by the sequencing of each micro-instruction and branch.
//   An overflow ends the item at the next fetch. Input errors and unknown
//   operations pass from the check state straight to the done state.
//   Reset clears the controller and the output valid; no clearing pass.
//   A stalled receiver holds the output beat stable until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         operation,
    input  wire logic signed [31:0] a_num,
    input  wire logic signed [31:0] a_den,
    input  wire logic signed [31:0] b_num,
    input  wire logic signed [31:0] b_den,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      result_num,
    output logic [30:0]             result_den,
    output logic                    less,
    output logic                    equal,
    output logic [1:0]              status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .stat      (stat)
    );

    // arithmetic
    rau_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .a_num      (a_num),
        .a_den      (a_den),
        .b_num      (b_num),
        .b_den      (b_den),
        .cmd        (cmd),
        .stat       (stat),
        .result_num (result_num),
        .result_den (result_den),
        .less       (less),
        .equal      (equal)
    );

endmodule

`default_nettype wire

>>> rtl/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_checker
    import rau_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [31:0] result_num,
    input wire logic [30:0]        result_den,
    input wire logic               less,
    input wire logic               equal,
    input wire logic [1:0]         status
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_num) &&
        $stable(result_den) && $stable(status))
        else $error("output beat changed under stall");

    // one item at a time: input stalls right after a beat
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    // error results carry the fixed fraction and no flags
    a_err_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |->
        result_num == 32'sd0 && result_den == 31'd1 && !less && !equal)
        else $error("error result not cleared");

    // denominator never zero, flags exclusive
    a_den_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_den != 31'd0 && !(less && equal))
        else $error("bad denominator or flags");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (.*);

`default_nettype wire
